### rtl/core/ycab_pkg.sv
// ----------------------------------------------------------------------------
// ycab_pkg
// Shared constants, widths and the sideband record of the YCbCr alpha blend.
// ----------------------------------------------------------------------------
package ycab_pkg;

  localparam int PIX_W       = 16;
  localparam int ALPHA_ONE   = 'h1000;
  localparam int MERGE_BIAS  = 'h1000800;
  localparam int ALPHA_SHIFT = 12;

  // bit window that a floor shift by ALPHA_SHIFT followed by a 16-bit wrap keeps
  localparam int SH_LO = ALPHA_SHIFT;
  localparam int SH_HI = ALPHA_SHIFT + PIX_W - 1;

  // signed dividends of the general branch fit 33 bits, magnitudes 32
  localparam int NUM_W      = 33;
  localparam int DIV_W      = NUM_W - 1;
  localparam int DVS_W      = 15;
  localparam int DIV_LANES  = 3;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = DIV_W / DIV_BPS;

  // color difference weights only matter modulo 2**QS_W
  localparam int QS_W = ALPHA_SHIFT + PIX_W;

  localparam logic MODE_LUMA  = 1'b0;
  localparam logic MODE_CDIFF = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic                 mode;
    logic                 general;
    logic                 m_zero;
    pix_t                 m;
    pix_t                 ry;
    pix_t                 rcb;
    pix_t                 rcr;
    pix_t                 ra;
    logic [DIV_LANES-1:0] q_neg;
    pix_t                 cb;
    pix_t                 cr;
    pix_t                 scb;
    pix_t                 scr;
  } side_t;

endpackage

### rtl/core/ycab_div.sv
// ----------------------------------------------------------------------------
// ycab_div
// Pipelined unsigned restoring divider, three lanes sharing one divisor,
// DIV_BPS quotient bits per stage, sideband carried along with each item.
// ----------------------------------------------------------------------------
module ycab_div import ycab_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [DIV_LANES-1:0][DIV_W-1:0]     in_num,
  input  logic [DVS_W-1:0]                    in_dvs,
  input  side_t                               in_side,
  output logic                                out_vld,
  output logic [DIV_LANES-1:0][DIV_W-1:0]     out_quo,
  output side_t                               out_side
);

  typedef logic [DIV_LANES-1:0][DIV_W-1:0] quo_t;
  typedef logic [DIV_LANES-1:0][DVS_W-1:0] rem_vec_t;

  logic             vld_src  [DIV_STAGES];
  quo_t             nq_src   [DIV_STAGES];
  rem_vec_t         rem_src  [DIV_STAGES];
  logic [DVS_W-1:0] dvs_src  [DIV_STAGES];
  side_t            side_src [DIV_STAGES];

  quo_t             nq_nxt   [DIV_STAGES];
  rem_vec_t         rem_nxt  [DIV_STAGES];

  logic             vld_r    [DIV_STAGES];
  quo_t             nq_r     [DIV_STAGES];
  rem_vec_t         rem_r    [DIV_STAGES];
  logic [DVS_W-1:0] dvs_r    [DIV_STAGES];
  side_t            side_r   [DIV_STAGES];

  logic [DVS_W-1:0] rem_w;
  logic [DIV_W-1:0] nq_w;
  logic [DVS_W:0]   trial_w;
  logic [DVS_W:0]   diff_w;

  // stage inputs: ports for the first stage, previous registers after that
  always_comb begin
    vld_src[0]  = in_vld;
    nq_src[0]   = in_num;
    rem_src[0]  = '0;
    dvs_src[0]  = in_dvs;
    side_src[0] = in_side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      vld_src[s]  = vld_r[s-1];
      nq_src[s]   = nq_r[s-1];
      rem_src[s]  = rem_r[s-1];
      dvs_src[s]  = dvs_r[s-1];
      side_src[s] = side_r[s-1];
    end
  end

  // dividend bits shift out at the top while quotient bits shift in below
  always_comb begin
    rem_w   = '0;
    nq_w    = '0;
    trial_w = '0;
    diff_w  = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        rem_w = rem_src[s][l];
        nq_w  = nq_src[s][l];
        for (int k = 0; k < DIV_BPS; k++) begin
          trial_w = {rem_w, nq_w[DIV_W-1]};
          nq_w    = {nq_w[DIV_W-2:0], 1'b0};
          diff_w  = trial_w - {1'b0, dvs_src[s]};
          if (trial_w >= {1'b0, dvs_src[s]}) begin
            rem_w   = diff_w[DVS_W-1:0];
            nq_w[0] = 1'b1;
          end else begin
            rem_w = trial_w[DVS_W-1:0];
          end
        end
        rem_nxt[s][l] = rem_w;
        nq_nxt[s][l]  = nq_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) vld_r[s] <= 1'b0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) vld_r[s] <= vld_src[s];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      nq_r[s]   <= nq_nxt[s];
      rem_r[s]  <= rem_nxt[s];
      dvs_r[s]  <= dvs_src[s];
      side_r[s] <= side_src[s];
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_quo  = nq_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];

endmodule

### rtl/core/ycbcr_alpha_channel_blend.sv
// ----------------------------------------------------------------------------
// ycbcr_alpha_channel_blend
// Straight-alpha compositing of a source over a destination YCbCr pixel in
// luminance or color difference mode, with a pipelined divide for the
// general branch.
// ----------------------------------------------------------------------------
//   channel   ports                                   handshake
//   -------   -------------------------------------   -------------------------
//   input     in_dst_*, in_src_*                      start high, busy low
//   result    out_luma/chroma_b/chroma_r/alpha/       out_valid, one cycle,
//             out_div_fault                           no back pressure
//   config    cfg_data (blend_mode)                   cfg_we
//
// One item per clock.
// The depth is set by the 8-stage divider (4 quotient bits per stage over a
// 32-bit magnitude), with 4 stages of products ahead of it and 3 behind it.
// busy stays low: nothing inside ever holds an item back.
// Reset clears blend_mode to luminance and empties every stage.
// ----------------------------------------------------------------------------
module ycbcr_alpha_channel_blend import ycab_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_data,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [PIX_W-1:0] in_dst_luma,
  input  logic signed [PIX_W-1:0] in_dst_chroma_b,
  input  logic signed [PIX_W-1:0] in_dst_chroma_r,
  input  logic signed [PIX_W-1:0] in_dst_alpha,
  input  logic signed [PIX_W-1:0] in_src_luma,
  input  logic signed [PIX_W-1:0] in_src_chroma_b,
  input  logic signed [PIX_W-1:0] in_src_chroma_r,
  input  logic signed [PIX_W-1:0] in_src_alpha,
  output logic                    out_valid,
  output logic signed [PIX_W-1:0] out_luma,
  output logic signed [PIX_W-1:0] out_chroma_b,
  output logic signed [PIX_W-1:0] out_chroma_r,
  output logic signed [PIX_W-1:0] out_alpha,
  output logic                    out_div_fault
);

  typedef enum logic [1:0] {
    BR_SRC_OPAQUE,
    BR_DST_OPAQUE,
    BR_DST_CLEAR,
    BR_GENERAL
  } branch_t;

  localparam logic signed [PIX_W:0]   A1X     = (PIX_W+1)'(ALPHA_ONE);
  localparam logic signed [NUM_W-1:0] BIAS_X  = NUM_W'(MERGE_BIAS);
  localparam pix_t                    A1_PIX  = PIX_W'(ALPHA_ONE);

  logic mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LUMA;
    end else if (cfg_we) begin
      mode_r <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // stage 1: branch decode and first products
  // --------------------------------------------------------------------------
  logic signed [PIX_W:0] oma_c, omsa_c, dy_c, dcb_c, dcr_c;
  branch_t               br_c;

  always_comb begin
    oma_c  = A1X - $signed({in_dst_alpha[PIX_W-1], in_dst_alpha});
    omsa_c = A1X - $signed({in_src_alpha[PIX_W-1], in_src_alpha});
    dy_c   = $signed({in_src_luma[PIX_W-1], in_src_luma})
           - $signed({in_dst_luma[PIX_W-1], in_dst_luma});
    dcb_c  = $signed({in_src_chroma_b[PIX_W-1], in_src_chroma_b})
           - $signed({in_dst_chroma_b[PIX_W-1], in_dst_chroma_b});
    dcr_c  = $signed({in_src_chroma_r[PIX_W-1], in_src_chroma_r})
           - $signed({in_dst_chroma_r[PIX_W-1], in_dst_chroma_r});
    priority if (in_src_alpha >= A1X) begin
      br_c = BR_SRC_OPAQUE;
    end else if (in_dst_alpha >= A1X) begin
      br_c = BR_DST_OPAQUE;
    end else if (in_dst_alpha <= 0) begin
      br_c = BR_DST_CLEAR;
    end else begin
      br_c = BR_GENERAL;
    end
  end

  logic                     s1_vld_r;
  logic                     s1_mode_r;
  branch_t                  s1_br_r;
  logic signed [31:0]       s1_ya_r, s1_cba_r, s1_cra_r, s1_pa_r, s1_sysa_r;
  logic signed [NUM_W-1:0]  s1_dy_r, s1_dcb_r, s1_dcr_r, s1_wdn_r;
  logic signed [PIX_W:0]    s1_omsa_r;
  logic signed [PIX_W-1:0]  s1_y_r, s1_cb_r, s1_cr_r, s1_sy_r, s1_scb_r, s1_scr_r, s1_sa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= mode_r;
    s1_br_r   <= br_c;
    s1_ya_r   <= in_dst_luma * in_dst_alpha;
    s1_cba_r  <= in_dst_chroma_b * in_dst_alpha;
    s1_cra_r  <= in_dst_chroma_r * in_dst_alpha;
    s1_pa_r   <= oma_c * omsa_c;
    s1_sysa_r <= in_src_luma * in_src_alpha;
    s1_dy_r   <= dy_c * in_src_alpha;
    s1_dcb_r  <= dcb_c * in_src_alpha;
    s1_dcr_r  <= dcr_c * in_src_alpha;
    s1_wdn_r  <= omsa_c * in_dst_alpha;
    s1_omsa_r <= omsa_c;
    s1_y_r    <= in_dst_luma;
    s1_cb_r   <= in_dst_chroma_b;
    s1_cr_r   <= in_dst_chroma_r;
    s1_sy_r   <= in_src_luma;
    s1_scb_r  <= in_src_chroma_b;
    s1_scr_r  <= in_src_chroma_r;
    s1_sa_r   <= in_src_alpha;
  end

  // --------------------------------------------------------------------------
  // stage 2: merged alpha and the results of the three simple branches
  // --------------------------------------------------------------------------
  logic signed [NUM_W-1:0] mdiff_c;
  pix_t                    m_c;
  side_t                   s2_side_c;

  always_comb begin
    mdiff_c = BIAS_X - $signed({s1_pa_r[31], s1_pa_r});
    m_c     = mdiff_c[SH_HI:SH_LO];

    s2_side_c         = '0;
    s2_side_c.mode    = s1_mode_r;
    s2_side_c.general = (s1_br_r == BR_GENERAL);
    s2_side_c.m       = m_c;
    s2_side_c.m_zero  = (m_c == '0);
    s2_side_c.cb      = s1_cb_r;
    s2_side_c.cr      = s1_cr_r;
    s2_side_c.scb     = s1_scb_r;
    s2_side_c.scr     = s1_scr_r;

    unique case (s1_mode_r)
      MODE_LUMA: begin
        unique case (s1_br_r)
          BR_SRC_OPAQUE: begin
            s2_side_c.ry  = s1_sy_r;
            s2_side_c.rcb = s1_cba_r[SH_HI:SH_LO];
            s2_side_c.rcr = s1_cra_r[SH_HI:SH_LO];
            s2_side_c.ra  = A1_PIX;
          end
          BR_DST_OPAQUE: begin
            s2_side_c.ry  = s1_y_r + s1_dy_r[SH_HI:SH_LO];
            s2_side_c.rcb = s1_cb_r;
            s2_side_c.rcr = s1_cr_r;
            s2_side_c.ra  = A1_PIX;
          end
          BR_DST_CLEAR: begin
            s2_side_c.ry  = s1_sy_r;
            s2_side_c.rcb = '0;
            s2_side_c.rcr = '0;
            s2_side_c.ra  = s1_sa_r;
          end
          default: begin
            s2_side_c.ry  = '0;
            s2_side_c.rcb = '0;
            s2_side_c.rcr = '0;
            s2_side_c.ra  = '0;
          end
        endcase
      end
      MODE_CDIFF: begin
        unique case (s1_br_r)
          BR_SRC_OPAQUE: begin
            s2_side_c.ry  = s1_ya_r[SH_HI:SH_LO];
            s2_side_c.rcb = s1_scb_r;
            s2_side_c.rcr = s1_scr_r;
            s2_side_c.ra  = A1_PIX;
          end
          BR_DST_OPAQUE: begin
            s2_side_c.ry  = s1_y_r;
            s2_side_c.rcb = s1_cb_r + s1_dcb_r[SH_HI:SH_LO];
            s2_side_c.rcr = s1_cr_r + s1_dcr_r[SH_HI:SH_LO];
            s2_side_c.ra  = A1_PIX;
          end
          BR_DST_CLEAR: begin
            s2_side_c.ry  = '0;
            s2_side_c.rcb = s1_scb_r;
            s2_side_c.rcr = s1_scr_r;
            s2_side_c.ra  = s1_sa_r;
          end
          default: begin
            s2_side_c.ry  = '0;
            s2_side_c.rcb = '0;
            s2_side_c.rcr = '0;
            s2_side_c.ra  = '0;
          end
        endcase
      end
      default: begin
        s2_side_c.ry = '0;
      end
    endcase
  end

  logic                    s2_vld_r;
  side_t                   s2_side_r;
  logic signed [PIX_W-1:0] s2_yash_r, s2_sa_r;
  logic signed [PIX_W:0]   s2_omsa_r;
  logic signed [31:0]      s2_sysa_r, s2_ya_r, s2_cba_r, s2_cra_r;
  logic signed [NUM_W-1:0] s2_wdn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r <= s2_side_c;
    s2_yash_r <= s1_ya_r[SH_HI:SH_LO];
    s2_omsa_r <= s1_omsa_r;
    s2_sysa_r <= s1_sysa_r;
    s2_ya_r   <= s1_ya_r;
    s2_cba_r  <= s1_cba_r;
    s2_cra_r  <= s1_cra_r;
    s2_wdn_r  <= s1_wdn_r;
    s2_sa_r   <= s1_sa_r;
  end

  // --------------------------------------------------------------------------
  // stage 3: dividends of the general branch
  // --------------------------------------------------------------------------
  logic signed [NUM_W:0]                  n0_lum_c;
  logic [DIV_LANES-1:0][NUM_W-1:0]        n_c;

  always_comb begin
    n0_lum_c = s2_yash_r * s2_omsa_r + s2_sysa_r;
    unique case (s2_side_r.mode)
      MODE_LUMA: begin
        n_c[0] = n0_lum_c[NUM_W-1:0];
        n_c[1] = {s2_cba_r[31], s2_cba_r};
        n_c[2] = {s2_cra_r[31], s2_cra_r};
      end
      MODE_CDIFF: begin
        n_c[0] = {s2_ya_r[31], s2_ya_r};
        n_c[1] = s2_wdn_r;
        n_c[2] = {{(NUM_W-PIX_W-ALPHA_SHIFT){s2_sa_r[PIX_W-1]}}, s2_sa_r,
                  {ALPHA_SHIFT{1'b0}}};
      end
      default: begin
        n_c = '0;
      end
    endcase
  end

  logic                            s3_vld_r;
  side_t                           s3_side_r;
  logic [DIV_LANES-1:0][NUM_W-1:0] s3_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_side_r <= s2_side_r;
    s3_n_r    <= n_c;
  end

  // --------------------------------------------------------------------------
  // stage 4: magnitudes and quotient signs (division truncates toward zero)
  // --------------------------------------------------------------------------
  logic [DIV_LANES-1:0][NUM_W-1:0] negn_c;
  logic [DIV_LANES-1:0][DIV_W-1:0] mag_c;
  pix_t                            mneg_c;
  logic                            dneg_c;
  logic [DVS_W-1:0]                dvs_c;
  side_t                           s4_side_c;

  always_comb begin
    dneg_c    = s3_side_r.m[PIX_W-1];
    mneg_c    = ~s3_side_r.m + 1'b1;
    dvs_c     = dneg_c ? mneg_c[DVS_W-1:0] : s3_side_r.m[DVS_W-1:0];
    s4_side_c = s3_side_r;
    for (int l = 0; l < DIV_LANES; l++) begin
      negn_c[l] = ~s3_n_r[l] + 1'b1;
      mag_c[l]  = s3_n_r[l][NUM_W-1] ? negn_c[l][DIV_W-1:0] : s3_n_r[l][DIV_W-1:0];
      s4_side_c.q_neg[l] = s3_n_r[l][NUM_W-1] ^ dneg_c;
    end
  end

  logic                            s4_vld_r;
  side_t                           s4_side_r;
  logic [DIV_LANES-1:0][DIV_W-1:0] s4_mag_r;
  logic [DVS_W-1:0]                s4_dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_side_r <= s4_side_c;
    s4_mag_r  <= mag_c;
    s4_dvs_r  <= dvs_c;
  end

  // --------------------------------------------------------------------------
  // divider
  // --------------------------------------------------------------------------
  logic                            dv_vld;
  logic [DIV_LANES-1:0][DIV_W-1:0] dv_quo;
  side_t                           dv_side;

  ycab_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_num   (s4_mag_r),
    .in_dvs   (s4_dvs_r),
    .in_side  (s4_side_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // --------------------------------------------------------------------------
  // post 1: signed quotients, kept modulo 2**QS_W
  // --------------------------------------------------------------------------
  logic [DIV_LANES-1:0][DIV_W-1:0] qn_c;
  logic [DIV_LANES-1:0][QS_W-1:0]  qs_c;

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      qn_c[l] = ~dv_quo[l] + 1'b1;
      qs_c[l] = dv_side.q_neg[l] ? qn_c[l][QS_W-1:0] : dv_quo[l][QS_W-1:0];
    end
  end

  logic                           p1_vld_r;
  side_t                          p1_side_r;
  logic [DIV_LANES-1:0][QS_W-1:0] p1_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_side_r <= dv_side;
    p1_q_r    <= qs_c;
  end

  // --------------------------------------------------------------------------
  // post 2: weighted chroma products for color difference mode
  // --------------------------------------------------------------------------
  logic signed [QS_W+PIX_W-1:0] pcb_d_c, pcb_s_c, pcr_d_c, pcr_s_c;

  always_comb begin
    // only the low QS_W bits are used, so the weight's sign view does not matter
    pcb_d_c = $signed(p1_side_r.cb)  * $signed(p1_q_r[1]);
    pcb_s_c = $signed(p1_side_r.scb) * $signed(p1_q_r[2]);
    pcr_d_c = $signed(p1_side_r.cr)  * $signed(p1_q_r[1]);
    pcr_s_c = $signed(p1_side_r.scr) * $signed(p1_q_r[2]);
  end

  logic                            p2_vld_r;
  side_t                           p2_side_r;
  logic [DIV_LANES-1:0][PIX_W-1:0] p2_q_r;
  logic [QS_W-1:0]                 p2_pcb_d_r, p2_pcb_s_r, p2_pcr_d_r, p2_pcr_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_side_r  <= p1_side_r;
    for (int l = 0; l < DIV_LANES; l++) begin
      p2_q_r[l] <= p1_q_r[l][PIX_W-1:0];
    end
    p2_pcb_d_r <= pcb_d_c[QS_W-1:0];
    p2_pcb_s_r <= pcb_s_c[QS_W-1:0];
    p2_pcr_d_r <= pcr_d_c[QS_W-1:0];
    p2_pcr_s_r <= pcr_s_c[QS_W-1:0];
  end

  // --------------------------------------------------------------------------
  // output stage: pick the branch result
  // --------------------------------------------------------------------------
  logic [QS_W-1:0] sum_cb_c, sum_cr_c;
  pix_t            ry_nxt, rcb_nxt, rcr_nxt, ra_nxt;
  logic            fault_nxt;

  always_comb begin
    sum_cb_c  = p2_pcb_d_r + p2_pcb_s_r;
    sum_cr_c  = p2_pcr_d_r + p2_pcr_s_r;
    fault_nxt = 1'b0;
    priority if (!p2_side_r.general) begin
      ry_nxt  = p2_side_r.ry;
      rcb_nxt = p2_side_r.rcb;
      rcr_nxt = p2_side_r.rcr;
      ra_nxt  = p2_side_r.ra;
    end else if (p2_side_r.m_zero) begin
      ry_nxt    = '0;
      rcb_nxt   = '0;
      rcr_nxt   = '0;
      ra_nxt    = '0;
      fault_nxt = 1'b1;
    end else if (p2_side_r.mode == MODE_LUMA) begin
      ry_nxt  = p2_q_r[0];
      rcb_nxt = p2_q_r[1];
      rcr_nxt = p2_q_r[2];
      ra_nxt  = p2_side_r.m;
    end else begin
      ry_nxt  = p2_q_r[0];
      rcb_nxt = sum_cb_c[SH_HI:SH_LO];
      rcr_nxt = sum_cr_c[SH_HI:SH_LO];
      ra_nxt  = p2_side_r.m;
    end
  end

  logic out_valid_r, fault_r;
  pix_t ry_r, rcb_r, rcr_r, ra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ry_r    <= ry_nxt;
    rcb_r   <= rcb_nxt;
    rcr_r   <= rcr_nxt;
    ra_r    <= ra_nxt;
    fault_r <= fault_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_luma      = ry_r;
  assign out_chroma_b  = rcb_r;
  assign out_chroma_r  = rcr_r;
  assign out_alpha     = ra_r;
  assign out_div_fault = fault_r;

endmodule

### dv/tb_ycbcr_alpha_channel_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ycbcr_alpha_channel_blend
// Drives destination/source pixel pairs into the alpha blend in both modes,
// predicts every composited pixel in a scoreboard and compares field by field.
// ----------------------------------------------------------------------------
module tb_ycbcr_alpha_channel_blend;
  import ycab_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 210;
  localparam int N_DIRECTED   = 12;

  typedef struct {
    logic signed [PIX_W-1:0] dy, dcb, dcr, da;
    logic signed [PIX_W-1:0] sy, scb, scr, sa;
  } pix_pair_t;

  typedef struct {
    logic signed [PIX_W-1:0] luma, cb, cr, alpha;
    logic                    fault;
  } blend_pix_t;

  class blend_scoreboard;
    logic       mode = MODE_LUMA;
    blend_pix_t expected_q[$];
    int         errors = 0;

    function blend_pix_t composite(pix_pair_t x, logic sel);
      longint y, cb, cr, a, sy, scb, scr, sa;
      longint ry, rcb, rcr, ra, mrg, dvs, wd, ws;
      logic signed [PIX_W-1:0] m16;
      blend_pix_t r;
      y = x.dy; cb = x.dcb; cr = x.dcr; a = x.da;
      sy = x.sy; scb = x.scb; scr = x.scr; sa = x.sa;
      r.fault = 1'b0;
      if (sa >= ALPHA_ONE) begin
        if (sel == MODE_LUMA) begin
          ry  = sy;
          rcb = (cb * a) >>> ALPHA_SHIFT;
          rcr = (cr * a) >>> ALPHA_SHIFT;
        end else begin
          ry  = (y * a) >>> ALPHA_SHIFT;
          rcb = scb;
          rcr = scr;
        end
        ra = ALPHA_ONE;
      end else if (a >= ALPHA_ONE) begin
        if (sel == MODE_LUMA) begin
          ry  = y + (((sy - y) * sa) >>> ALPHA_SHIFT);
          rcb = cb;
          rcr = cr;
        end else begin
          ry  = y;
          rcb = cb + (((scb - cb) * sa) >>> ALPHA_SHIFT);
          rcr = cr + (((scr - cr) * sa) >>> ALPHA_SHIFT);
        end
        ra = ALPHA_ONE;
      end else if (a <= 0) begin
        if (sel == MODE_LUMA) begin
          ry  = sy;
          rcb = 0;
          rcr = 0;
        end else begin
          ry  = 0;
          rcb = scb;
          rcr = scr;
        end
        ra = sa;
      end else begin
        mrg = (MERGE_BIAS - (ALPHA_ONE - a) * (ALPHA_ONE - sa)) >>> ALPHA_SHIFT;
        // luma mode divides by the merged alpha after the 16-bit wrap
        m16 = mrg[PIX_W-1:0];
        dvs = (sel == MODE_LUMA) ? longint'(m16) : mrg;
        if (dvs == 0) begin
          ry = 0; rcb = 0; rcr = 0; ra = 0;
          r.fault = 1'b1;
        end else if (sel == MODE_LUMA) begin
          ry  = ((((y * a) >>> ALPHA_SHIFT) * (ALPHA_ONE - sa)) + sy * sa) / dvs;
          rcb = cb * a / dvs;
          rcr = cr * a / dvs;
          ra  = dvs;
        end else begin
          wd  = (ALPHA_ONE - sa) * a / dvs;
          ws  = (sa * ALPHA_ONE) / dvs;
          ry  = y * a / dvs;
          rcb = (cb * wd + scb * ws) >>> ALPHA_SHIFT;
          rcr = (cr * wd + scr * ws) >>> ALPHA_SHIFT;
          ra  = dvs;
        end
      end
      r.luma  = ry[PIX_W-1:0];
      r.cb    = rcb[PIX_W-1:0];
      r.cr    = rcr[PIX_W-1:0];
      r.alpha = ra[PIX_W-1:0];
      return r;
    endfunction

    function void note_item(pix_pair_t x);
      expected_q.push_back(composite(x, mode));
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(blend_pix_t got);
      blend_pix_t want;
      if (expected_q.size() == 0) begin
        $error("out_valid: result with no item outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("out_luma", want.luma, got.luma);
      compare("out_chroma_b", want.cb, got.cb);
      compare("out_chroma_r", want.cr, got.cr);
      compare("out_alpha", want.alpha, got.alpha);
      compare("out_div_fault", want.fault, got.fault);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [PIX_W-1:0] in_dst_luma = '0, in_dst_chroma_b = '0;
  logic signed [PIX_W-1:0] in_dst_chroma_r = '0, in_dst_alpha = '0;
  logic signed [PIX_W-1:0] in_src_luma = '0, in_src_chroma_b = '0;
  logic signed [PIX_W-1:0] in_src_chroma_r = '0, in_src_alpha = '0;
  logic out_valid;
  logic signed [PIX_W-1:0] out_luma, out_chroma_b, out_chroma_r, out_alpha;
  logic out_div_fault;

  blend_scoreboard sb = new();
  int unsigned stall_cycles = 0;

  ycbcr_alpha_channel_blend i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_dst_luma     (in_dst_luma),
    .in_dst_chroma_b (in_dst_chroma_b),
    .in_dst_chroma_r (in_dst_chroma_r),
    .in_dst_alpha    (in_dst_alpha),
    .in_src_luma     (in_src_luma),
    .in_src_chroma_b (in_src_chroma_b),
    .in_src_chroma_r (in_src_chroma_r),
    .in_src_alpha    (in_src_alpha),
    .out_valid       (out_valid),
    .out_luma        (out_luma),
    .out_chroma_b    (out_chroma_b),
    .out_chroma_r    (out_chroma_r),
    .out_alpha       (out_alpha),
    .out_div_fault   (out_div_fault)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // results are checked before new items are noted, both at the same edge
  always @(posedge clk) begin
    pix_pair_t  taken;
    blend_pix_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.luma  = out_luma;
        got.cb    = out_chroma_b;
        got.cr    = out_chroma_r;
        got.alpha = out_alpha;
        got.fault = out_div_fault;
        sb.check_result(got);
      end
      if (start && !busy) begin
        taken.dy  = in_dst_luma;
        taken.dcb = in_dst_chroma_b;
        taken.dcr = in_dst_chroma_r;
        taken.da  = in_dst_alpha;
        taken.sy  = in_src_luma;
        taken.scb = in_src_chroma_b;
        taken.scr = in_src_chroma_r;
        taken.sa  = in_src_alpha;
        sb.note_item(taken);
      end
      if (cfg_we)
        sb.mode = cfg_data;
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic pix_pair_t make_pair(int dy, int dcb, int dcr, int da,
                                          int sy, int scb, int scr, int sa);
    pix_pair_t p;
    p.dy = PIX_W'(dy); p.dcb = PIX_W'(dcb); p.dcr = PIX_W'(dcr); p.da = PIX_W'(da);
    p.sy = PIX_W'(sy); p.scb = PIX_W'(scb); p.scr = PIX_W'(scr); p.sa = PIX_W'(sa);
    return p;
  endfunction

  function automatic pix_pair_t directed_pair(int k);
    case (k)
      // source exactly opaque
      0:  return make_pair(32767, 32767, -32768, 4096, -32768, 32767, -32768, 4096);
      // source alpha max over the most negative destination alpha
      1:  return make_pair(-32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
      // destination opaque
      2:  return make_pair(-32768, 1234, -1234, 32767, 32767, 0, 0, 2048);
      3:  return make_pair(32767, -5, 5, 4096, -32768, 32767, -32768, -32768);
      // destination transparent
      4:  return make_pair(1000, 2000, -3000, 0, -400, 500, -600, 1000);
      5:  return make_pair(-1, -1, -1, -32768, 32767, 32767, 32767, -32768);
      // general branch
      6:  return make_pair(4096, -2048, 2048, 2048, 1024, 512, -512, 2048);
      7:  return make_pair(32767, 32767, 32767, 1, -32768, -32768, -32768, 4095);
      // merged alpha of zero
      8:  return make_pair(100, 200, 300, 1, 400, 500, 600, -1);
      // general branch with a negative source alpha
      9:  return make_pair(-32768, -32768, -32768, 4095, 32767, 32767, 32767, -32768);
      10: return make_pair(7, -7, 7, 45, -7, 7, -7, -45);
      default: return make_pair(0, 0, 0, 4095, 0, 0, 0, 4095);
    endcase
  endfunction

  function automatic logic signed [PIX_W-1:0] rand_pix();
    case ($urandom_range(9))
      0:       return PIX_W'(-32768);
      1:       return PIX_W'(32767);
      2:       return '0;
      3, 4, 5: return PIX_W'(int'($urandom_range(8191)) - 4096);
      default: return PIX_W'($urandom_range(65535));
    endcase
  endfunction

  // alpha values cluster around the branch boundaries
  function automatic logic signed [PIX_W-1:0] rand_alpha();
    case ($urandom_range(11))
      0:          return PIX_W'(ALPHA_ONE);
      1:          return PIX_W'(ALPHA_ONE - 1);
      2:          return '0;
      3:          return PIX_W'(1);
      4:          return PIX_W'($urandom_range(32767, ALPHA_ONE + 1));
      5:          return PIX_W'(-int'($urandom_range(32768, 1)));
      6, 7, 8, 9: return PIX_W'($urandom_range(ALPHA_ONE - 1, 1));
      10:         return $urandom_range(1) ? PIX_W'(32767) : PIX_W'(-32768);
      default:    return PIX_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic pix_pair_t rand_pair();
    pix_pair_t p;
    int a;
    p.dy = rand_pix(); p.dcb = rand_pix(); p.dcr = rand_pix(); p.da = rand_alpha();
    p.sy = rand_pix(); p.scb = rand_pix(); p.scr = rand_pix(); p.sa = rand_alpha();
    // small dst alpha against its negative lands the merged alpha on or near zero
    if ($urandom_range(15) == 0) begin
      a = $urandom_range(45, 1);
      p.da = PIX_W'(a);
      p.sa = PIX_W'(-a + int'($urandom_range(4)) - 2);
    end
    return p;
  endfunction

  task automatic drive_item(pix_pair_t p, int idle_pct);
    @(negedge clk);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_dst_luma     <= p.dy;
    in_dst_chroma_b <= p.dcb;
    in_dst_chroma_r <= p.dcr;
    in_dst_alpha    <= p.da;
    in_src_luma     <= p.sy;
    in_src_chroma_b <= p.scb;
    in_src_chroma_r <= p.scr;
    in_src_alpha    <= p.sa;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic sel);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= sel;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int idle_pct [4];
    idle_pct = '{0, 57, 0, 29};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items, first in the reset mode, then in color difference mode
    for (int k = 0; k < N_DIRECTED; k++) drive_item(directed_pair(k), 0);
    wait_drained();
    write_mode(MODE_CDIFF);
    for (int k = 0; k < N_DIRECTED; k++) drive_item(directed_pair(k), 0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_mode((ph % 2) ? MODE_CDIFF : MODE_LUMA);
      for (int n = 0; n < PHASE_ITEMS; n++) drive_item(rand_pair(), idle_pct[ph / 2]);
    end

    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
